### design/nirs_pkg.sv
// ----------------------------------------------------------------------------
// nirs_pkg: shared constants for the nearest-id ring search
// Frame geometry, id width, field widths and command codes.
// ----------------------------------------------------------------------------
`default_nettype none

package nirs_pkg;

  localparam int FRAME_WIDTH  = 1024;
  localparam int FRAME_HEIGHT = 512;
  localparam int ID_BITS      = 16;
  localparam int RADIUS_LIMIT = 15;

  localparam int STORE_DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);

  localparam int RADIUS_W     = 4;
  localparam int POS_X_W      = 10;
  localparam int POS_Y_W      = 9;
  localparam int OUT_ID_W     = 16;

  // signed cell coordinates: centre plus or minus the largest radius
  localparam int CX_W         = POS_X_W + 2;
  localparam int CY_W         = POS_Y_W + 2;
  // ring step index, up to twice the largest radius
  localparam int IDX_W        = RADIUS_W + 1;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

endpackage

`default_nettype wire

### design/nirs_ram.sv
// ----------------------------------------------------------------------------
// nirs_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nirs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### design/nearest_id_ring_search.sv
// ----------------------------------------------------------------------------
// nearest_id_ring_search: per-pixel id buffer with nearest-id ring query
// Usage:
//   Input channel (in_valid/in_ready) carries a command, a pixel and an id.
//   A write (cmd 0) stores the id at the pixel and gives no
//   result; pixels outside the frame are ignored.
//   A query (cmd 1) scans square rings of radius 0 up to max_radius around
//   the pixel, one cell read per cycle from the id RAM, and returns the
//   first nonzero id on the out_ channel with a found flag.
//   A query holds in_ready low through its scan (the centre cell is read
//   twice, and reads pass the two-stage read pipe) and the done state;
//   radius 15 covers 961 cells. out_valid rises as in_ready returns.
//   The single RAM read port sets the pace.
//   cfg_wr_en/cfg_wr_data write max_radius (reset 15); the user must
//   write it only while idle; the block does not enforce it. After reset,
//   in_ready is low while all 524288 RAM entries clear, one per cycle.
//   The result sits in an output register; a stalled receiver holds it and
//   writes may still be taken, while the next query waits for the slot.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_id_ring_search
  import nirs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_cmd,
  input  wire logic [POS_X_W-1:0]  in_pos_x,
  input  wire logic [POS_Y_W-1:0]  in_pos_y,
  input  wire logic [15:0]         in_write_id,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_found,
  output logic [OUT_ID_W-1:0]      out_object_id,
  input  wire logic                cfg_wr_en,
  input  wire logic [RADIUS_W-1:0] cfg_wr_data
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  // control
  logic [1:0]          state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [RADIUS_W-1:0] max_radius_r, max_radius_nxt;
  logic                issue_r, issue_nxt;
  logic                s1_valid_r, s1_valid_nxt;
  logic                s2_valid_r, s2_valid_nxt;
  logic                out_valid_r, out_valid_nxt;

  // sequencer position and payload
  logic signed [CX_W-1:0] cx_r, cx_nxt;
  logic signed [CY_W-1:0] cy_r, cy_nxt;
  logic [RADIUS_W-1:0]    rad_r, rad_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic                   side_r, side_nxt;
  logic                   col_phase_r, col_phase_nxt;
  logic                   s1_last_r, s1_last_nxt;
  logic signed [CX_W-1:0] x_r, x_nxt;
  logic signed [CY_W-1:0] y_r, y_nxt;
  logic                   s2_last_r, s2_last_nxt;
  logic                   s2_in_r, s2_in_nxt;
  logic                   res_found_r, res_found_nxt;
  logic [OUT_ID_W-1:0]    res_id_r, res_id_nxt;
  logic                   out_found_r, out_found_nxt;
  logic [OUT_ID_W-1:0]    out_id_r, out_id_nxt;

  // ring cell generator
  logic signed [CX_W-1:0] rad_x, idx_x, lo_x, hi_x, cell_x;
  logic signed [CY_W-1:0] rad_y, idx_y, lo_y, hi_y, cell_y;
  logic [IDX_W-1:0]       two_r;
  logic                   ring_end, issue_last;

  // RAM ports
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [ID_BITS-1:0] ram_wdata, ram_rdata;

  logic in_xfer, wr_in_frame, s1_in_frame, hit, scan_done, out_free;

  assign rad_x  = signed'(CX_W'(rad_r));
  assign idx_x  = signed'(CX_W'(idx_r));
  assign rad_y  = signed'(CY_W'(rad_r));
  assign idx_y  = signed'(CY_W'(idx_r));
  assign lo_x   = cx_r - rad_x;
  assign hi_x   = cx_r + rad_x;
  assign lo_y   = cy_r - rad_y;
  assign hi_y   = cy_r + rad_y;
  assign cell_x = col_phase_r ? (side_r ? lo_x : hi_x) : lo_x + idx_x;
  assign cell_y = col_phase_r ? lo_y + idx_y : (side_r ? lo_y : hi_y);
  assign two_r  = {rad_r, 1'b0};

  assign ring_end   = side_r && (col_phase_r ? (idx_r == two_r - IDX_W'(1))
                                             : (rad_r == '0));
  assign issue_last = ring_end && (rad_r == max_radius_r);

  assign in_ready    = (state_r == ST_IDLE);
  assign in_xfer     = in_valid && in_ready;
  assign wr_in_frame = (int'(in_pos_x) < FRAME_WIDTH) && (int'(in_pos_y) < FRAME_HEIGHT);
  assign s1_in_frame = (int'(x_r) >= 0) && (int'(x_r) < FRAME_WIDTH) &&
                       (int'(y_r) >= 0) && (int'(y_r) < FRAME_HEIGHT);

  assign hit       = s2_valid_r && s2_in_r && (ram_rdata != '0);
  assign scan_done = hit || (s2_valid_r && s2_last_r);
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ADDR_W'(in_pos_y) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(in_pos_x);
    ram_wdata = ID_BITS'(in_write_id);
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else if (in_xfer && (in_cmd == CMD_WRITE) && wr_in_frame) begin
      ram_we = 1'b1;
    end
  end

  assign ram_raddr = ADDR_W'(y_r[CY_W-2:0]) * ADDR_W'(FRAME_WIDTH) +
                     ADDR_W'(x_r[CX_W-2:0]);

  nirs_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_id_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    max_radius_nxt = cfg_wr_en ? cfg_wr_data : max_radius_r;
    issue_nxt      = issue_r;
    s1_valid_nxt   = 1'b0;
    s2_valid_nxt   = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    rad_nxt        = rad_r;
    idx_nxt        = idx_r;
    side_nxt       = side_r;
    col_phase_nxt  = col_phase_r;
    s1_last_nxt    = issue_last;
    x_nxt          = cell_x;
    y_nxt          = cell_y;
    s2_last_nxt    = s1_last_r;
    s2_in_nxt      = s1_in_frame;
    res_found_nxt  = res_found_r;
    res_id_nxt     = res_id_r;
    out_found_nxt  = out_found_r;
    out_id_nxt     = out_id_r;

    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(STORE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer && (in_cmd == CMD_QUERY)) begin
          cx_nxt        = signed'(CX_W'(in_pos_x));
          cy_nxt        = signed'(CY_W'(in_pos_y));
          rad_nxt       = '0;
          idx_nxt       = '0;
          side_nxt      = 1'b0;
          col_phase_nxt = 1'b0;
          issue_nxt     = 1'b1;
          state_nxt     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        s1_valid_nxt = issue_r;
        s2_valid_nxt = s1_valid_r;
        if (issue_r) begin
          if (!side_r) begin
            side_nxt = 1'b1;
          end else begin
            side_nxt = 1'b0;
            if (ring_end) begin
              rad_nxt       = rad_r + RADIUS_W'(1);
              idx_nxt       = '0;
              col_phase_nxt = 1'b0;
              if (issue_last) begin
                issue_nxt = 1'b0;
              end
            end else if (!col_phase_r && (idx_r == two_r)) begin
              col_phase_nxt = 1'b1;
              idx_nxt       = IDX_W'(1);
            end else begin
              idx_nxt = idx_r + IDX_W'(1);
            end
          end
        end
        if (scan_done) begin
          res_found_nxt = hit;
          res_id_nxt    = hit ? OUT_ID_W'(ram_rdata) : '0;
          issue_nxt     = 1'b0;
          s1_valid_nxt  = 1'b0;
          s2_valid_nxt  = 1'b0;
          state_nxt     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_id_nxt    = res_id_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      max_radius_r <= RADIUS_W'(RADIUS_LIMIT);
      issue_r      <= 1'b0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      max_radius_r <= max_radius_nxt;
      issue_r      <= issue_nxt;
      s1_valid_r   <= s1_valid_nxt;
      s2_valid_r   <= s2_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    rad_r       <= rad_nxt;
    idx_r       <= idx_nxt;
    side_r      <= side_nxt;
    col_phase_r <= col_phase_nxt;
    s1_last_r   <= s1_last_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    s2_last_r   <= s2_last_nxt;
    s2_in_r     <= s2_in_nxt;
    res_found_r <= res_found_nxt;
    res_id_r    <= res_id_nxt;
    out_found_r <= out_found_nxt;
    out_id_r    <= out_id_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_object_id = out_id_r;

  // read pipeline only runs during a query scan
  a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r || s2_valid_r) |-> (state_r == ST_SCAN))
    else $error("read pipeline active outside scan");

  // a finished scan lands in the output register once the output slot is free
  a_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DONE) && out_free) |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("scan result not delivered");

  // no match means an empty id
  a_empty_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_id_r == '0))
    else $error("id reported without a match");

  // no RAM write from the input side while a query is in flight
  a_no_write_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) || (state_r == ST_DONE)) |-> !ram_we)
    else $error("RAM write during query");

endmodule

`default_nettype wire
